// File: rtl/c8ie_pkg.sv
// ----------------------------------------------------------------------------
// c8ie_pkg: shared types and constants
// Transfer structs, opcode codes, controller commands and the hex font.
// ----------------------------------------------------------------------------
`default_nettype none
package c8ie_pkg;

    localparam int ADDR_W        = 12;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int FRAME_PIXELS  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_MEM_SIZE    = 4096;
    localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

    // actions
    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_PIXEL = 2'd2;

    // opcode groups
    localparam logic [3:0] GRP_SYS    = 4'h0;
    localparam logic [3:0] GRP_JP     = 4'h1;
    localparam logic [3:0] GRP_CALL   = 4'h2;
    localparam logic [3:0] GRP_SEQ_NN = 4'h3;
    localparam logic [3:0] GRP_SNE_NN = 4'h4;
    localparam logic [3:0] GRP_SEQ    = 4'h5;
    localparam logic [3:0] GRP_LD     = 4'h6;
    localparam logic [3:0] GRP_ADD    = 4'h7;
    localparam logic [3:0] GRP_ALU    = 4'h8;
    localparam logic [3:0] GRP_SNE    = 4'h9;
    localparam logic [3:0] GRP_LDI    = 4'hA;
    localparam logic [3:0] GRP_JPV    = 4'hB;
    localparam logic [3:0] GRP_RND    = 4'hC;
    localparam logic [3:0] GRP_DRW    = 4'hD;

    localparam logic [ADDR_W-1:0] NNN_CLS = 12'h0E0;
    localparam logic [ADDR_W-1:0] NNN_RET = 12'h0EE;

    // 8XYn operations
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [3:0] FLAG_REG = 4'hF;

    typedef struct packed {
        logic [1:0]        action;
        logic [15:0]       instruction;
        logic [7:0]        random_byte;
        logic [ADDR_W-1:0] location;
        logic [7:0]        write_byte;
    } in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] next_pc;
        logic [ADDR_W-1:0] index_value;
        logic [7:0]        flag_value;
        logic              pixel_value;
        logic              stack_fault;
    } out_t;

    typedef struct packed {
        logic init_step;   // reset sweep of memory and frame
        logic ld_in;       // capture input transfer
        logic rd_regs;     // registered reads of regs, stack, frame
        logic exec;        // perform the item
        logic fclr_step;   // clear one frame row
        logic dmod_step;   // reduce sprite address into memory range
        logic dfetch;      // read sprite byte and frame row
        logic dwrite;      // xor row back, next row
        logic out_load;    // load result register
    } cmd_t;

    typedef struct packed {
        logic init_done;
        logic fclr_done;
        logic is_clear;
        logic is_draw;
        logic mod_done;
        logic n_zero;
        logic rows_last;
        logic out_free;
    } stat_t;

    function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
        logic [7:0] v;
        case (a)
            12'd0:  v = 8'hF0; 12'd1:  v = 8'h90; 12'd2:  v = 8'h90; 12'd3:  v = 8'h90;
            12'd4:  v = 8'hF0; 12'd5:  v = 8'h20; 12'd6:  v = 8'h60; 12'd7:  v = 8'h20;
            12'd8:  v = 8'h20; 12'd9:  v = 8'h70; 12'd10: v = 8'hF0; 12'd11: v = 8'h10;
            12'd12: v = 8'hF0; 12'd13: v = 8'h80; 12'd14: v = 8'hF0; 12'd15: v = 8'hF0;
            12'd16: v = 8'h10; 12'd17: v = 8'hF0; 12'd18: v = 8'h10; 12'd19: v = 8'hF0;
            12'd20: v = 8'h90; 12'd21: v = 8'h90; 12'd22: v = 8'hF0; 12'd23: v = 8'h10;
            12'd24: v = 8'h10; 12'd25: v = 8'hF0; 12'd26: v = 8'h80; 12'd27: v = 8'hF0;
            12'd28: v = 8'h10; 12'd29: v = 8'hF0; 12'd30: v = 8'hF0; 12'd31: v = 8'h80;
            12'd32: v = 8'hF0; 12'd33: v = 8'h90; 12'd34: v = 8'hF0; 12'd35: v = 8'hF0;
            12'd36: v = 8'h10; 12'd37: v = 8'h20; 12'd38: v = 8'h40; 12'd39: v = 8'h40;
            12'd40: v = 8'hF0; 12'd41: v = 8'h90; 12'd42: v = 8'hF0; 12'd43: v = 8'h90;
            12'd44: v = 8'hF0; 12'd45: v = 8'hF0; 12'd46: v = 8'h90; 12'd47: v = 8'hF0;
            12'd48: v = 8'h10; 12'd49: v = 8'hF0; 12'd50: v = 8'hF0; 12'd51: v = 8'h90;
            12'd52: v = 8'hF0; 12'd53: v = 8'h90; 12'd54: v = 8'h90; 12'd55: v = 8'hE0;
            12'd56: v = 8'h90; 12'd57: v = 8'hE0; 12'd58: v = 8'h90; 12'd59: v = 8'hE0;
            12'd60: v = 8'hF0; 12'd61: v = 8'h80; 12'd62: v = 8'h80; 12'd63: v = 8'h80;
            12'd64: v = 8'hF0; 12'd65: v = 8'hE0; 12'd66: v = 8'h90; 12'd67: v = 8'h90;
            12'd68: v = 8'h90; 12'd69: v = 8'hE0; 12'd70: v = 8'hF0; 12'd71: v = 8'h80;
            12'd72: v = 8'hF0; 12'd73: v = 8'h80; 12'd74: v = 8'hF0; 12'd75: v = 8'hF0;
            12'd76: v = 8'h80; 12'd77: v = 8'hF0; 12'd78: v = 8'h80; 12'd79: v = 8'h80;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/c8ie_ctrl.sv
// ----------------------------------------------------------------------------
// c8ie_ctrl: sequencing state machine
// Steps each item through read, execute, clear/draw loops and result load.
// ----------------------------------------------------------------------------
`default_nettype none
module c8ie_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  c8ie_pkg::stat_t    st,
    output c8ie_pkg::cmd_t     cmd
);
    import c8ie_pkg::*;

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_READ   = 9'b000000100,
        S_EXEC   = 9'b000001000,
        S_FCLR   = 9'b000010000,
        S_DMOD   = 9'b000100000,
        S_DFETCH = 9'b001000000,
        S_DWRITE = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (st.init_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_in  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_regs = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (st.is_clear)
                    state_next = S_FCLR;
                else if (st.is_draw)
                    state_next = S_DMOD;
                else
                    state_next = S_OUT;
            end
            S_FCLR:
            begin
                cmd.fclr_step = 1'b1;
                if (st.fclr_done)
                    state_next = S_OUT;
            end
            S_DMOD:
            begin
                if (st.mod_done)
                    state_next = st.n_zero ? S_OUT : S_DFETCH;
                else
                    cmd.dmod_step = 1'b1;
            end
            S_DFETCH:
            begin
                cmd.dfetch = 1'b1;
                state_next = S_DWRITE;
            end
            S_DWRITE:
            begin
                cmd.dwrite = 1'b1;
                state_next = st.rows_last ? S_OUT : S_DFETCH;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cmd) <= 1)
        else $error("more than one command at once");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_in |=> state_reg == S_READ)
        else $error("accept did not start a read");
    a_draw_path: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dfetch |=> cmd.dwrite)
        else $error("fetch not followed by write-back");

endmodule
`default_nettype wire

// File: rtl/c8ie_dpath.sv
// ----------------------------------------------------------------------------
// c8ie_dpath: machine state and execution datapath
// Registers, stack, main memory, frame rows and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module c8ie_dpath #(
    parameter int STACK_DEPTH = c8ie_pkg::DEF_STACK_DEPTH,
    parameter int MEM_SIZE    = c8ie_pkg::DEF_MEM_SIZE
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  c8ie_pkg::in_t     in_data,
    input  wire logic         out_stall,
    output logic              out_valid,
    output c8ie_pkg::out_t    out_data,
    input  c8ie_pkg::cmd_t    cmd,
    output c8ie_pkg::stat_t   st
);
    import c8ie_pkg::*;

    localparam int AW  = $clog2(MEM_SIZE);
    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int SLW = $clog2(STACK_DEPTH + 1);
    localparam logic [ADDR_W:0] MEM_LIM = (ADDR_W+1)'(MEM_SIZE);

    in_t               in_reg;
    logic [7:0]        vr [16];
    logic [7:0]        rx_reg, ry_reg;
    logic [ADDR_W-1:0] pc_reg, i_reg;
    logic [SLW-1:0]    sp_reg;
    logic [ADDR_W-1:0] stack [STACK_DEPTH];
    logic [ADDR_W-1:0] stk_rd_reg;
    logic [7:0]        mem [MEM_SIZE];
    logic [7:0]        mem_rd_reg;
    logic [SCREEN_WIDTH-1:0] frame [SCREEN_HEIGHT];
    logic [SCREEN_WIDTH-1:0] frame_rd_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [3:0]        row_reg;
    logic              fault_reg, pix_reg;
    logic              out_valid_reg;
    out_t              out_reg;

    // opcode fields
    logic [3:0]        grp, rx_a, ry_a, nlo;
    logic [7:0]        nn;
    logic [ADDR_W-1:0] nnn, pc2, pc4;
    assign grp  = in_reg.instruction[15:12];
    assign rx_a = in_reg.instruction[11:8];
    assign ry_a = in_reg.instruction[7:4];
    assign nlo  = in_reg.instruction[3:0];
    assign nn   = in_reg.instruction[7:0];
    assign nnn  = in_reg.instruction[11:0];
    assign pc2  = pc_reg + 12'd2;
    assign pc4  = pc_reg + 12'd4;

    logic is_exec;
    assign is_exec = (in_reg.action == ACT_EXEC);

    // execute decode
    logic              vx_we, vf_we, i_we, push, pop, flt;
    logic [7:0]        vx_d, vf_d;
    logic [ADDR_W-1:0] pc_d;
    logic [8:0]        sum9;
    logic              stk_full, stk_empty;
    assign stk_full  = (sp_reg == SLW'(STACK_DEPTH));
    assign stk_empty = (sp_reg == '0);
    assign sum9      = {1'b0, rx_reg} + {1'b0, ry_reg};

    always_comb
    begin
        vx_we = 1'b0; vf_we = 1'b0; i_we = 1'b0;
        push = 1'b0; pop = 1'b0; flt = 1'b0;
        vx_d = '0; vf_d = '0; pc_d = pc2;
        case (grp)
            GRP_SYS:
            begin
                if (nnn == NNN_CLS)
                    pc_d = pc2;
                else if (nnn == NNN_RET)
                begin
                    if (stk_empty)
                        flt = 1'b1;
                    else
                    begin
                        pop  = 1'b1;
                        pc_d = stk_rd_reg + 12'd2;
                    end
                end
                else if (stk_full)
                    flt = 1'b1;
                else
                begin
                    push = 1'b1;
                    pc_d = nnn;
                end
            end
            GRP_CALL:
            begin
                if (stk_full)
                    flt = 1'b1;
                else
                begin
                    push = 1'b1;
                    pc_d = nnn;
                end
            end
            GRP_JP:     pc_d = nnn;
            GRP_SEQ_NN: pc_d = (rx_reg == nn) ? pc4 : pc2;
            GRP_SNE_NN: pc_d = (rx_reg != nn) ? pc4 : pc2;
            GRP_SEQ:    pc_d = (rx_reg == ry_reg) ? pc4 : pc2;
            GRP_SNE:    pc_d = (rx_reg != ry_reg) ? pc4 : pc2;
            GRP_LD:     begin vx_we = 1'b1; vx_d = nn; end
            GRP_ADD:    begin vx_we = 1'b1; vx_d = rx_reg + nn; end
            GRP_LDI:    i_we = 1'b1;
            GRP_JPV:    pc_d = nnn + {4'd0, rx_reg};
            GRP_RND:    begin vx_we = 1'b1; vx_d = in_reg.random_byte & nn; end
            GRP_DRW:    begin vf_we = 1'b1; vf_d = '0; end
            GRP_ALU:
            begin
                case (nlo)
                    ALU_MOV: begin vx_we = 1'b1; vx_d = ry_reg; end
                    ALU_OR:  begin vx_we = 1'b1; vx_d = rx_reg | ry_reg; end
                    ALU_AND: begin vx_we = 1'b1; vx_d = rx_reg & ry_reg; end
                    ALU_XOR: begin vx_we = 1'b1; vx_d = rx_reg ^ ry_reg; end
                    ALU_ADD:
                    begin
                        vx_we = 1'b1; vx_d = sum9[7:0];
                        vf_we = 1'b1; vf_d = {7'd0, sum9[8]};
                    end
                    ALU_SUB:
                    begin
                        vx_we = 1'b1; vx_d = rx_reg - ry_reg;
                        vf_we = 1'b1; vf_d = {7'd0, rx_reg >= ry_reg};
                    end
                    ALU_SUBN:
                    begin
                        vx_we = 1'b1; vx_d = ry_reg - rx_reg;
                        vf_we = 1'b1; vf_d = {7'd0, ry_reg >= rx_reg};
                    end
                    ALU_SHR:
                    begin
                        vx_we = 1'b1; vx_d = {1'b0, rx_reg[7:1]};
                        vf_we = 1'b1; vf_d = {7'd0, rx_reg[0]};
                    end
                    ALU_SHL:
                    begin
                        vx_we = 1'b1; vx_d = {rx_reg[6:0], 1'b0};
                        vf_we = 1'b1; vf_d = {7'd0, rx_reg[7]};
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // sprite row placed at x0 with horizontal wrap
    logic [COL_W-1:0]        x0;
    logic [ROW_W-1:0]        yrow;
    logic [SCREEN_WIDTH-1:0] mask;
    logic                    hit;
    assign x0   = rx_reg[COL_W-1:0];
    assign yrow = ry_reg[ROW_W-1:0] + ROW_W'(row_reg);
    always_comb
    begin
        mask = '0;
        for (int c = 0; c < 8; c++)
            mask[COL_W'(x0 + COL_W'(c))] = mem_rd_reg[3'(7 - c)];
    end
    assign hit = |(mask & frame_rd_reg);

    logic [ADDR_W:0] addr_inc;
    assign addr_inc = {1'b0, addr_reg} + 13'd1;

    // control registers and register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
                vr[k] <= '0;
            pc_reg    <= PC_RESET;
            i_reg     <= '0;
            sp_reg    <= '0;
            cnt_reg   <= '0;
            addr_reg  <= '0;
            row_reg   <= '0;
            fault_reg <= 1'b0;
            pix_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.init_step || cmd.fclr_step)
                cnt_reg <= cnt_reg + 12'd1;
            if (cmd.ld_in)
            begin
                fault_reg <= 1'b0;
                pix_reg   <= 1'b0;
            end
            if (cmd.exec)
            begin
                cnt_reg <= '0;
                if (is_exec)
                begin
                    pc_reg    <= pc_d;
                    fault_reg <= flt;
                    if (i_we)
                        i_reg <= nnn;
                    if (push)
                        sp_reg <= sp_reg + SLW'(1);
                    if (pop)
                        sp_reg <= sp_reg - SLW'(1);
                    // with VF as target the flag takes the slot
                    if (vx_we && !(vf_we && rx_a == FLAG_REG))
                        vr[rx_a] <= vx_d;
                    if (vf_we)
                        vr[FLAG_REG] <= vf_d;
                    addr_reg <= i_reg;
                    row_reg  <= '0;
                end
                else if (in_reg.action == ACT_PIXEL)
                    pix_reg <= (in_reg.location < ADDR_W'(FRAME_PIXELS)) &&
                               frame_rd_reg[in_reg.location[COL_W-1:0]];
            end
            if (cmd.dmod_step)
                addr_reg <= addr_reg - ADDR_W'(MEM_SIZE);
            if (cmd.dwrite)
            begin
                if (hit)
                    vr[FLAG_REG] <= 8'd1;
                row_reg  <= row_reg + 4'd1;
                addr_reg <= (addr_inc == MEM_LIM) ? '0 : addr_inc[ADDR_W-1:0];
            end
        end
    end

    // register read ports
    always_ff @(posedge clk)
    begin
        if (cmd.rd_regs)
        begin
            rx_reg <= vr[(grp == GRP_JPV) ? 4'd0 : rx_a];
            ry_reg <= vr[ry_a];
        end
    end

    // call stack
    always_ff @(posedge clk)
    begin
        if (cmd.exec && is_exec && push)
            stack[sp_reg[SPW-1:0]] <= pc_reg;
        if (cmd.rd_regs)
            stk_rd_reg <= stack[stk_empty ? '0 : SPW'(sp_reg - SLW'(1))];
    end

    // main memory
    always_ff @(posedge clk)
    begin
        if (cmd.init_step)
            mem[cnt_reg[AW-1:0]] <= font_byte(cnt_reg);
        else if (cmd.exec && (in_reg.action == ACT_WRITE) &&
                 ({1'b0, in_reg.location} < MEM_LIM))
            mem[in_reg.location[AW-1:0]] <= in_reg.write_byte;
        if (cmd.dfetch)
            mem_rd_reg <= mem[addr_reg[AW-1:0]];
    end

    // frame, one word per screen row
    always_ff @(posedge clk)
    begin
        if (cmd.init_step || cmd.fclr_step)
            frame[cnt_reg[ROW_W-1:0]] <= '0;
        else if (cmd.dwrite)
            frame[yrow] <= frame_rd_reg ^ mask;
        if (cmd.rd_regs)
            frame_rd_reg <= frame[in_reg.location[COL_W+ROW_W-1:COL_W]];
        else if (cmd.dfetch)
            frame_rd_reg <= frame[yrow];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
            in_reg <= in_data;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.next_pc     <= pc_reg;
            out_reg.index_value <= i_reg;
            out_reg.flag_value  <= vr[FLAG_REG];
            out_reg.pixel_value <= pix_reg;
            out_reg.stack_fault <= fault_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign st.init_done = (cnt_reg == ADDR_W'(MEM_SIZE - 1));
    assign st.fclr_done = (cnt_reg[ROW_W-1:0] == ROW_W'(SCREEN_HEIGHT - 1));
    assign st.is_clear  = is_exec && (grp == GRP_SYS) && (nnn == NNN_CLS);
    assign st.is_draw   = is_exec && (grp == GRP_DRW);
    assign st.mod_done  = ({1'b0, addr_reg} < MEM_LIM);
    assign st.n_zero    = (nlo == 4'd0);
    assign st.rows_last = (row_reg == nlo - 4'd1);
    assign st.out_free  = !out_valid_reg || !out_stall;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SLW'(STACK_DEPTH))
        else $error("stack level beyond depth");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");
    a_fetch_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dfetch |-> ({1'b0, addr_reg} < MEM_LIM))
        else $error("sprite fetch outside memory");
    a_pix_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && in_reg.action != ACT_PIXEL) |=> !pix_reg)
        else $error("pixel set by a non-read item");

endmodule
`default_nettype wire

// File: rtl/chip8_instruction_execute.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute: CHIP-8 opcode execution block
// Executes one opcode, memory write or pixel read per input transfer.
// ----------------------------------------------------------------------------
// Sequence: most items pass accept, register read, execute and result load,
//   the load waiting on output stall; 00E0 adds a clear per frame row; DXYN
//   adds address reduction, then a fetch and a write-back per sprite row.
// Throughput: one item at a time; the next is accepted once the result is
//   loaded, while that result may still wait in the output register.
// Reset: a MEM_SIZE-word sweep (4096 by default) loads the font, clears
//   the rest of memory and the frame; no input is accepted until it ends.
`default_nettype none
module chip8_instruction_execute #(
    parameter int STACK_DEPTH = c8ie_pkg::DEF_STACK_DEPTH,
    parameter int MEM_SIZE    = c8ie_pkg::DEF_MEM_SIZE
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  c8ie_pkg::in_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output c8ie_pkg::out_t   out_data
);
    import c8ie_pkg::*;

    // controller drives at most one command per cycle; datapath answers with status
    cmd_t  cmd;
    stat_t st;

    c8ie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath holds all machine state: V0..VF, I, PC, stack, memory, frame
    c8ie_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .MEM_SIZE    (MEM_SIZE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
`default_nettype wire
